### rtl/pes_pkg.sv
// Package for the SHA-256 register-extend block: payload types, constants and
// the SHA-256 round table and helper functions. No dependencies.
`default_nettype none
package pes_pkg;
    localparam int unsigned DefNumRegisters = 32;
    localparam int unsigned WordsPerReg = 4;

    typedef enum logic [0:0] {
        OP_EXTEND = 1'b0,
        OP_CHECK  = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        CFG_QUOTE0 = 2'd0,
        CFG_QUOTE1 = 2'd1,
        CFG_QUOTE2 = 2'd2,
        CFG_QUOTE3 = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic        opcode;
        logic [4:0]  pcr_index;
        logic [63:0] digest_word0;
        logic [63:0] digest_word1;
        logic [63:0] digest_word2;
        logic [63:0] digest_word3;
    } t_in_req;

    typedef struct packed {
        logic [4:0]  index_out;
        logic [63:0] value_word0;
        logic [63:0] value_word1;
        logic [63:0] value_word2;
        logic [63:0] value_word3;
        logic        violation;
        logic        quote_match;
    } t_out_req;

    localparam logic [255:0] HInit = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    function automatic logic [31:0] k_round(input logic [5:0] i);
        logic [31:0] k;
        unique case (i)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction
endpackage
`default_nettype wire

### rtl/pes_core.sv
// SHA-256 compression core: one round per cycle, 64 rounds plus a final add.
// Depends on pes_pkg.
`default_nettype none
module pes_core import pes_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [255:0] i_h,
    input  wire logic [511:0] i_blk,
    output logic              o_done,
    output logic [255:0]      o_h
);
    logic [31:0]  r_w [16];
    logic [31:0]  r_v [8];
    logic [255:0] r_h;
    logic [5:0]   r_round;
    logic         r_busy;
    logic         r_done;

    logic [31:0] s0, s1, w_new, t1, t2, ch, maj, e_s, a_s;

    always_comb begin
        s0    = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1    = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = r_w[0] + s0 + r_w[9] + s1;
        e_s   = rotr(r_v[4], 6) ^ rotr(r_v[4], 11) ^ rotr(r_v[4], 25);
        ch    = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1    = r_v[7] + e_s + ch + k_round(r_round) + r_w[0];
        a_s   = rotr(r_v[0], 2) ^ rotr(r_v[0], 13) ^ rotr(r_v[0], 22);
        maj   = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2    = a_s + maj;
    end

    // Control: count rounds while busy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_round <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_round <= '0;
            end else if (r_busy) begin
                r_round <= r_round + 6'd1;
                if (r_round == 6'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: load, then advance schedule window and working variables
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_h <= i_h;
            for (int i = 0; i < 16; i++) r_w[i] <= i_blk[511 - 32*i -: 32];
            for (int i = 0; i < 8; i++) r_v[i] <= i_h[255 - 32*i -: 32];
        end else if (r_busy) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_new;
            r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    assign o_done = r_done;
    always_comb begin
        for (int i = 0; i < 8; i++) o_h[255 - 32*i -: 32] = r_h[255 - 32*i -: 32] + r_v[i];
    end
endmodule
`default_nettype wire

### rtl/pcr_extend_sha256.sv
// Register-extend block with SHA-256. An extend runs memory fetch, two compressions,
// write-back and output; the quote check adds a third compression and a wait state
// after the write-back; an index beyond the bank goes from the fetch state to output.
// One request at a time, set by the single shared round-per-cycle compression core;
// the next request is taken once the result has left.
// Reset: synchronous active low; a clearing pass zeroes memory.
`default_nettype none
module pcr_extend_sha256 import pes_pkg::*; #(
    parameter int unsigned NUM_REGISTERS = DefNumRegisters
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_stall,
    input  wire t_in_req  i_req,
    output logic          o_valid,
    input  wire logic     i_stall,
    output t_out_req      o_req,
    input  wire logic     i_cfg_valid,
    output logic          o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);
    localparam int unsigned Depth = NUM_REGISTERS * WordsPerReg;
    localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_READ  = 9'b000000100,
        S_HASH1 = 9'b000001000,
        S_HASH2 = 9'b000010000,
        S_WRITE = 9'b000100000,
        S_HASH3 = 9'b001000000,
        S_OUT   = 9'b010000000,
        S_WAIT  = 9'b100000000
    } t_state;

    t_state         r_state;
    logic [63:0]    mem [Depth];
    logic [63:0]    r_rdata;
    logic [AW-1:0]  r_addr;
    logic [2:0]     r_cnt;
    logic           r_we;
    logic [63:0]    r_wdata;
    logic [255:0]   r_old, r_dig, r_hash;
    logic [63:0]    r_quote [4];
    t_in_req        r_in;
    logic           r_viol;
    logic           r_valid_out;
    t_out_req       r_out;
    logic           r_core_start;
    logic           core_busy;
    logic           core_done;
    logic [255:0]   core_h_in, core_h_out;
    logic [511:0]   core_blk;
    logic           in_range;
    logic           accept;

    assign in_range = 32'(r_in.pcr_index) < NUM_REGISTERS;
    assign accept   = i_valid && !o_stall;
    assign o_stall  = (r_state != S_IDLE) || r_valid_out;
    assign o_cfg_ready = 1'b1;

    // Register memory: one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (r_we) mem[r_addr] <= r_wdata;
        r_rdata <= mem[r_addr];
    end

    // Quote registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) r_quote[i] <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_QUOTE0: r_quote[0] <= i_cfg_data;
                CFG_QUOTE1: r_quote[1] <= i_cfg_data;
                CFG_QUOTE2: r_quote[2] <= i_cfg_data;
                CFG_QUOTE3: r_quote[3] <= i_cfg_data;
            endcase
        end
    end

    // Core inputs follow the phase
    always_comb begin
        core_h_in = (r_state == S_HASH2) ? r_hash : HInit;
        unique case (r_state)
            S_HASH2: core_blk = {32'h80000000, 448'd0, 32'd512};
            S_HASH3: core_blk = {r_hash, 32'h80000000, 192'd0, 32'd256};
            default: core_blk = {r_old, r_dig};
        endcase
    end

    pes_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_core_start),
        .i_h     (core_h_in),
        .i_blk   (core_blk),
        .o_done  (core_done),
        .o_h     (core_h_out)
    );
    assign core_busy = (r_state == S_HASH1) || (r_state == S_HASH2) || (r_state == S_HASH3);

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_addr       <= '0;
            r_we         <= 1'b1;
            r_wdata      <= '0;
            r_cnt        <= '0;
            r_valid_out  <= 1'b0;
            r_core_start <= 1'b0;
        end else begin
            r_core_start <= 1'b0;
            r_we         <= 1'b0;
            if (r_valid_out && !i_stall) r_valid_out <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    if (32'(r_addr) == Depth - 1) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_addr <= r_addr + AW'(1);
                        r_we   <= 1'b1;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_in   <= i_req;
                        r_viol <= ({i_req.digest_word0, i_req.digest_word1,
                                    i_req.digest_word2, i_req.digest_word3} == '0);
                        r_dig  <= ({i_req.digest_word0, i_req.digest_word1,
                                    i_req.digest_word2, i_req.digest_word3} == '0) ? '1 :
                                  {i_req.digest_word0, i_req.digest_word1,
                                   i_req.digest_word2, i_req.digest_word3};
                        r_addr <= AW'({i_req.pcr_index, 2'b00});
                        r_cnt  <= '0;
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    // Fetch four words; read data arrives in the cycle after its address
                    if (!in_range) begin
                        r_hash  <= '0;
                        r_state <= S_OUT;
                    end else begin
                        if (r_cnt != 3'd0) r_old <= {r_old[191:0], r_rdata};
                        if (r_cnt == 3'd4) begin
                            r_core_start <= 1'b1;
                            r_state      <= S_HASH1;
                        end else begin
                            r_cnt <= r_cnt + 3'd1;
                            if (r_cnt != 3'd3) r_addr <= r_addr + AW'(1);
                        end
                    end
                end
                S_HASH1: begin
                    if (core_done) begin
                        r_hash       <= core_h_out;
                        r_core_start <= 1'b1;
                        r_state      <= S_HASH2;
                    end
                end
                S_HASH2: begin
                    if (core_done) begin
                        r_hash  <= core_h_out;
                        r_old   <= core_h_out;
                        r_addr  <= AW'({r_in.pcr_index, 2'b00});
                        r_cnt   <= '0;
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_we    <= 1'b1;
                    r_wdata <= r_old[255:192];
                    r_old   <= {r_old[191:0], 64'd0};
                    if (r_cnt != 3'd0) r_addr <= r_addr + AW'(1);
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd3) begin
                        if (r_in.opcode == OP_CHECK) begin
                            r_core_start <= 1'b1;
                            r_state      <= S_HASH3;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_HASH3: begin
                    if (core_done) r_state <= S_WAIT;
                    r_old <= core_h_out;
                end
                S_WAIT: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_out.index_out   <= r_in.pcr_index;
                    r_out.value_word0 <= r_hash[255:192];
                    r_out.value_word1 <= r_hash[191:128];
                    r_out.value_word2 <= r_hash[127:64];
                    r_out.value_word3 <= r_hash[63:0];
                    r_out.violation   <= r_viol;
                    r_out.quote_match <= in_range && (r_in.opcode == OP_CHECK) &&
                        (r_old == {r_quote[0], r_quote[1], r_quote[2], r_quote[3]});
                    r_valid_out <= 1'b1;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_valid_out;
    assign o_req   = r_out;

    // Checks
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !accept) else $error("request taken while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_req))) else $error("result dropped");
    a_core_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_core_start |=> core_busy) else $error("core start outside hash phase");
endmodule
`default_nettype wire
